// ===== rtl/qkr_pkg.sv =====
`default_nettype none

package qkr_pkg;

   // Default sizes of the queue.
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int TEXT_BYTES_DEF  = 20;

   // Command codes.
   localparam logic [2:0] CMD_APPEND   = 3'd0;
   localparam logic [2:0] CMD_REM_HEAD = 3'd1;
   localparam logic [2:0] CMD_REM_TAIL = 3'd2;
   localparam logic [2:0] CMD_REM_KEY  = 3'd3;
   localparam logic [2:0] CMD_READ_OUT = 3'd4;

   // Status codes.
   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_NOKEY = 2'd2;
   localparam logic [1:0] STATUS_FULL  = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SHIFT,
      ST_READ
   } state_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [15:0] entry_key;
      logic [63:0] name_word_a;
      logic [63:0] name_word_b;
      logic [31:0] name_word_c;
      logic [63:0] car_word_a;
      logic [63:0] car_word_b;
      logic [31:0] car_word_c;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] out_key;
      logic [63:0] out_name_a;
      logic [63:0] out_name_b;
      logic [31:0] out_name_c;
      logic [63:0] out_car_a;
      logic [63:0] out_car_b;
      logic [31:0] out_car_c;
      logic        last_of_run;
   } rsp_type;

   // One stored queue entry.
   typedef struct packed {
      logic [15:0] key;
      logic [63:0] name_a;
      logic [63:0] name_b;
      logic [31:0] name_c;
      logic [63:0] car_a;
      logic [63:0] car_b;
      logic [31:0] car_c;
   } entry_type;

   // Keeps the bytes of a 64-bit text word, starting at byte position base,
   // that lie below text_bytes.
   function automatic logic [63:0] text_mask(input int text_bytes, input int base);
      logic [63:0] m;
      m = '0;
      for (int b = 0; b < 8; b++) begin
         if (base + b < text_bytes) begin
            m[8*b +: 8] = 8'hFF;
         end
      end
      return m;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/queue_with_keyed_removal_top.sv =====
// Append, remove tail, refused or empty commands answer in the cycle after start.
// Remove head and remove by key answer when their memory walk ends. Read out streams
// one item per cycle, head first, until the item marked last.
// One command runs at a time; busy stays high while the memory walk runs.
// Reset (synchronous, active high) empties the queue; the entry memory is not cleared.
`default_nettype none

module queue_with_keyed_removal_top
   import qkr_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int TEXT_BYTES  = TEXT_BYTES_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_strobe,
   output rsp_type      rsp_item
);

   // Address width of the entry memory and width of the entry count,
   // which must also hold the full depth.
   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

   // Byte masks for the three words of each text field.
   localparam logic [63:0] MASK_A = text_mask(TEXT_BYTES, 0);
   localparam logic [63:0] MASK_B = text_mask(TEXT_BYTES, 8);
   localparam logic [63:0] MASK_C = text_mask(TEXT_BYTES, 16);

   // The queue lives in one memory, entry 0 being the head. Removal at the head
   // or by key closes the gap by copying each later entry one place toward the head.
   entry_type entry_mem [QUEUE_DEPTH];

   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   iss_ff, iss_in;     // next memory index to read
   logic [15:0]     key_ff, key_in;     // key searched for
   logic            rd_valid_ff;        // rd_data_ff holds a fresh read
   logic [CW-1:0]   rd_idx_ff;          // index that rd_data_ff came from
   entry_type       rd_data_ff;
   logic            rsp_strobe_ff, rsp_strobe_in;
   rsp_type         rsp_item_ff, rsp_item_in;

   logic            rd_en;
   logic [AW-1:0]   rd_addr;
   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   entry_type       wr_data;
   entry_type       new_entry;
   logic            issue_more;
   logic            last_data;
   logic [CW-1:0]   rd_idx_prev;

   always_comb begin
      new_entry.key    = req_item.entry_key;
      new_entry.name_a = req_item.name_word_a & MASK_A;
      new_entry.name_b = req_item.name_word_b & MASK_B;
      new_entry.name_c = req_item.name_word_c & MASK_C[31:0];
      new_entry.car_a  = req_item.car_word_a & MASK_A;
      new_entry.car_b  = req_item.car_word_b & MASK_B;
      new_entry.car_c  = req_item.car_word_c & MASK_C[31:0];
   end

   assign issue_more  = (iss_ff < count_ff);
   assign last_data   = rd_valid_ff && (rd_idx_ff == (count_ff - CW'(1)));
   assign rd_idx_prev = rd_idx_ff - CW'(1);

   // Next state, memory control and result composition.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      iss_in        = iss_ff;
      key_in        = key_ff;
      rd_en         = 1'b0;
      rd_addr       = iss_ff[AW-1:0];
      wr_en         = 1'b0;
      wr_addr       = rd_idx_prev[AW-1:0];
      wr_data       = rd_data_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rsp_item_in.last_of_run = 1'b1;
               unique case (req_item.command)
                  CMD_APPEND: begin
                     rsp_strobe_in = 1'b1;
                     if (count_ff == DEPTH_C) begin
                        rsp_item_in.status = STATUS_FULL;
                     end else begin
                        wr_en              = 1'b1;
                        wr_addr            = count_ff[AW-1:0];
                        wr_data            = new_entry;
                        count_in           = count_ff + CW'(1);
                        rsp_item_in.status = STATUS_DONE;
                     end
                  end
                  CMD_REM_HEAD: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in      = 1'b1;
                        rsp_item_in.status = STATUS_EMPTY;
                     end else begin
                        // Copy entries 1 and up one place toward the head.
                        iss_in   = CW'(1);
                        state_in = ST_SHIFT;
                     end
                  end
                  CMD_REM_TAIL: begin
                     rsp_strobe_in = 1'b1;
                     if (count_ff == '0) begin
                        rsp_item_in.status = STATUS_EMPTY;
                     end else begin
                        count_in           = count_ff - CW'(1);
                        rsp_item_in.status = STATUS_DONE;
                     end
                  end
                  CMD_REM_KEY: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in      = 1'b1;
                        rsp_item_in.status = STATUS_EMPTY;
                     end else begin
                        key_in   = req_item.entry_key;
                        iss_in   = '0;
                        state_in = ST_SEARCH;
                     end
                  end
                  CMD_READ_OUT: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in      = 1'b1;
                        rsp_item_in.status = STATUS_EMPTY;
                     end else begin
                        iss_in   = '0;
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                     // Unused codes are answered as done and change nothing.
                     rsp_strobe_in      = 1'b1;
                     rsp_item_in.status = STATUS_DONE;
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            // Reads keep streaming; the read issued in the cycle of a match
            // is already the first entry that the shift needs.
            rd_en = issue_more;
            if (issue_more) begin
               iss_in = iss_ff + CW'(1);
            end
            if (rd_valid_ff) begin
               if (rd_data_ff.key == key_ff) begin
                  state_in = ST_SHIFT;
               end else if (last_data) begin
                  rsp_strobe_in           = 1'b1;
                  rsp_item_in.status      = STATUS_NOKEY;
                  rsp_item_in.last_of_run = 1'b1;
                  state_in                = ST_IDLE;
               end
            end
         end
         ST_SHIFT: begin
            // Each entry read at index i is written back at index i - 1.
            // Writes trail reads, so no access overlaps on one entry.
            rd_en = issue_more;
            if (issue_more) begin
               iss_in = iss_ff + CW'(1);
            end
            if (rd_valid_ff) begin
               wr_en = 1'b1;
            end
            if (!issue_more && !rd_valid_ff) begin
               count_in                = count_ff - CW'(1);
               rsp_strobe_in           = 1'b1;
               rsp_item_in.status      = STATUS_DONE;
               rsp_item_in.last_of_run = 1'b1;
               state_in                = ST_IDLE;
            end
         end
         ST_READ: begin
            rd_en = issue_more;
            if (issue_more) begin
               iss_in = iss_ff + CW'(1);
            end
            if (rd_valid_ff) begin
               rsp_strobe_in           = 1'b1;
               rsp_item_in.status      = STATUS_DONE;
               rsp_item_in.out_key     = rd_data_ff.key;
               rsp_item_in.out_name_a  = rd_data_ff.name_a;
               rsp_item_in.out_name_b  = rd_data_ff.name_b;
               rsp_item_in.out_name_c  = rd_data_ff.name_c;
               rsp_item_in.out_car_a   = rd_data_ff.car_a;
               rsp_item_in.out_car_b   = rd_data_ff.car_b;
               rsp_item_in.out_car_c   = rd_data_ff.car_c;
               rsp_item_in.last_of_run = last_data;
               if (last_data) begin
                  state_in = ST_IDLE;
               end
            end
         end
      endcase
   end

   // Entry memory: one write port, one read port with registered data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rd_valid_ff   <= rd_en;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      iss_ff      <= iss_in;
      key_ff      <= key_in;
      rd_idx_ff   <= iss_ff;
      rsp_item_ff <= rsp_item_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

`ifndef SYNTHESIS
   // A memory walk only ever runs over a non-empty queue.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (count_ff != '0))
      else $error("memory walk running on an empty queue");

   // Read-out items stream without gaps until the one marked last.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_item.last_of_run) |=> rsp_strobe)
      else $error("gap inside a read-out run");

   // An append to a full queue is refused and leaves the count alone.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.command == CMD_APPEND) && (count_ff == DEPTH_C))
      |=> (rsp_strobe && (rsp_item.status == STATUS_FULL) && $stable(count_ff)))
      else $error("append to a full queue not refused");

   // The count never exceeds the queue depth.
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == DEPTH_C) |=> (count_ff <= DEPTH_C))
      else $error("entry count beyond queue depth");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

// Testbench for the keyed-removal queue.
//
// A driver feeds commands from a queue of pending items over the start/busy
// handshake. Each time an item is accepted, a shadow copy of the queue in the
// bench works out the answers that the block must give. The bench stores
// those answers in order. A monitor takes every strobed result and checks it,
// field by field, against the oldest stored answer. The receiver cannot hold
// results off, so idling is applied only on the command side.

module tb_top;
   import qkr_pkg::*;

   // Command codes 5 to 7 have no function. The block must still answer each
   // of them with one plain done result.
   localparam logic [2:0] CMD_SPARE_LO = 3'd5;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;

   localparam int DEPTH       = QUEUE_DEPTH_DEF;
   localparam int TEXT_LEN    = TEXT_BYTES_DEF;
   localparam int IDLE_PCT    = 23;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_WAIT  = 40;
   localparam int PRINT_CAP   = 40;
   localparam int RANDOM_CMDS = 420;

   typedef enum logic [1:0] {
      TEXT_ZERO,
      TEXT_ONES,
      TEXT_RANDOM
   } text_fill_type;

   logic    clock      = 1'b0;
   logic    reset      = 1'b1;
   logic    start      = 1'b0;
   req_type req_item   = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_item;

   // Commands waiting to be driven, the bench's copy of the stored entries
   // (head at index 0), and the answers still owed by the block.
   req_type   pending_cmds[$];
   entry_type shadow_entries[$];
   rsp_type   owed_answers[$];

   int mismatch_count = 0;
   int accepted_count = 0;
   int quiet_cycles   = 0;

   queue_with_keyed_removal_top u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Text bytes at or beyond the configured text length are stored as zero.
   function automatic logic [63:0] trim_text(input logic [63:0] word, input int base);
      logic [63:0] kept;
      kept = word;
      for (int b = 0; b < 8; b++) begin
         if (base + b >= TEXT_LEN) begin
            kept[8*b +: 8] = 8'h00;
         end
      end
      return kept;
   endfunction

   // Applies one accepted command to the shadow queue and records the answers
   // that it must produce. Every command answers once, except a read-out of a
   // non-empty queue, which answers once per entry from head to tail.
   function automatic void track_command(input req_type cmd);
      rsp_type   answer;
      entry_type fresh;
      int        hit;
      bit        streamed;
      answer             = '0;
      answer.status      = STATUS_DONE;
      answer.last_of_run = 1'b1;
      streamed           = 1'b0;
      hit                = -1;
      case (cmd.command)
         CMD_APPEND: begin
            if (shadow_entries.size() >= DEPTH) begin
               answer.status = STATUS_FULL;
            end else begin
               fresh.key    = cmd.entry_key;
               fresh.name_a = trim_text(cmd.name_word_a, 0);
               fresh.name_b = trim_text(cmd.name_word_b, 8);
               fresh.name_c = 32'(trim_text({32'h0, cmd.name_word_c}, 16));
               fresh.car_a  = trim_text(cmd.car_word_a, 0);
               fresh.car_b  = trim_text(cmd.car_word_b, 8);
               fresh.car_c  = 32'(trim_text({32'h0, cmd.car_word_c}, 16));
               shadow_entries.push_back(fresh);
            end
         end
         CMD_REM_HEAD, CMD_REM_TAIL: begin
            if (shadow_entries.size() == 0) begin
               answer.status = STATUS_EMPTY;
            end else if (cmd.command == CMD_REM_HEAD) begin
               void'(shadow_entries.pop_front());
            end else begin
               void'(shadow_entries.pop_back());
            end
         end
         CMD_REM_KEY: begin
            if (shadow_entries.size() == 0) begin
               answer.status = STATUS_EMPTY;
            end else begin
               // Only the match nearest the head goes; later duplicates stay.
               for (int i = 0; i < shadow_entries.size() && hit < 0; i++) begin
                  if (shadow_entries[i].key == cmd.entry_key) begin
                     hit = i;
                  end
               end
               if (hit < 0) begin
                  answer.status = STATUS_NOKEY;
               end else begin
                  shadow_entries.delete(hit);
               end
            end
         end
         CMD_READ_OUT: begin
            if (shadow_entries.size() == 0) begin
               answer.status = STATUS_EMPTY;
            end else begin
               streamed = 1'b1;
               for (int i = 0; i < shadow_entries.size(); i++) begin
                  answer.out_key     = shadow_entries[i].key;
                  answer.out_name_a  = shadow_entries[i].name_a;
                  answer.out_name_b  = shadow_entries[i].name_b;
                  answer.out_name_c  = shadow_entries[i].name_c;
                  answer.out_car_a   = shadow_entries[i].car_a;
                  answer.out_car_b   = shadow_entries[i].car_b;
                  answer.out_car_c   = shadow_entries[i].car_c;
                  answer.last_of_run = (i == shadow_entries.size() - 1);
                  owed_answers.push_back(answer);
               end
            end
         end
         default: begin
            // Spare codes leave the state alone.
         end
      endcase
      if (!streamed) begin
         owed_answers.push_back(answer);
      end
   endfunction

   function automatic req_type make_cmd(input logic [2:0] code, input logic [15:0] key,
                                        input text_fill_type fill);
      req_type cmd;
      cmd.command   = code;
      cmd.entry_key = key;
      case (fill)
         TEXT_ZERO: begin
            cmd.name_word_a = '0;
            cmd.name_word_b = '0;
            cmd.name_word_c = '0;
            cmd.car_word_a  = '0;
            cmd.car_word_b  = '0;
            cmd.car_word_c  = '0;
         end
         TEXT_ONES: begin
            cmd.name_word_a = '1;
            cmd.name_word_b = '1;
            cmd.name_word_c = '1;
            cmd.car_word_a  = '1;
            cmd.car_word_b  = '1;
            cmd.car_word_c  = '1;
         end
         default: begin
            cmd.name_word_a = {$urandom(), $urandom()};
            cmd.name_word_b = {$urandom(), $urandom()};
            cmd.name_word_c = $urandom();
            cmd.car_word_a  = {$urandom(), $urandom()};
            cmd.car_word_b  = {$urandom(), $urandom()};
            cmd.car_word_c  = $urandom();
         end
      endcase
      return cmd;
   endfunction

   // Keys mostly come from a small pool, so that removal by key finds matches
   // and duplicates are common. The rest span the whole key range.
   function automatic logic [15:0] pick_key();
      if ($urandom_range(99) < 80) begin
         return 16'($urandom_range(7));
      end
      return 16'($urandom());
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < PRINT_CAP) begin
         $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
      end
      mismatch_count++;
   endtask

   // Driver. An item counts as taken at an edge where start is high and busy
   // is low. A refused item stays on the port. Otherwise the next item goes
   // out unless this cycle is an idle one. A long stretch of items in the
   // middle of the run is driven back to back.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            track_command(req_item);
            accepted_count++;
         end
         if (start && busy) begin
            // Hold the current item until the block takes it.
         end else if (pending_cmds.size() != 0 &&
                      ((accepted_count >= 150 && accepted_count < 260) ||
                       $urandom_range(99) >= IDLE_PCT)) begin
            req_item <= pending_cmds.pop_front();
            start    <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor. Each strobed result is checked against the oldest owed answer.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (owed_answers.size() == 0) begin
            report_mismatch("result with nothing expected", 64'(rsp_item.status), 64'h0);
         end else begin
            want = owed_answers.pop_front();
            if (rsp_item.status !== want.status)
               report_mismatch("status", 64'(rsp_item.status), 64'(want.status));
            if (rsp_item.out_key !== want.out_key)
               report_mismatch("out_key", 64'(rsp_item.out_key), 64'(want.out_key));
            if (rsp_item.out_name_a !== want.out_name_a)
               report_mismatch("out_name_a", rsp_item.out_name_a, want.out_name_a);
            if (rsp_item.out_name_b !== want.out_name_b)
               report_mismatch("out_name_b", rsp_item.out_name_b, want.out_name_b);
            if (rsp_item.out_name_c !== want.out_name_c)
               report_mismatch("out_name_c", 64'(rsp_item.out_name_c), 64'(want.out_name_c));
            if (rsp_item.out_car_a !== want.out_car_a)
               report_mismatch("out_car_a", rsp_item.out_car_a, want.out_car_a);
            if (rsp_item.out_car_b !== want.out_car_b)
               report_mismatch("out_car_b", rsp_item.out_car_b, want.out_car_b);
            if (rsp_item.out_car_c !== want.out_car_c)
               report_mismatch("out_car_c", 64'(rsp_item.out_car_c), 64'(want.out_car_c));
            if (rsp_item.last_of_run !== want.last_of_run)
               report_mismatch("last_of_run", 64'(rsp_item.last_of_run),
                               64'(want.last_of_run));
         end
      end
   end

   // Watchdog. The longest correct silence is a full-depth removal that waits
   // behind an idle gap. The limit is far above that.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("queue_with_keyed_removal_top: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int          pick;
      int          append_pct;
      logic [2:0]  code;
      logic [15:0] key;

      // Directed part. Every removal first meets an empty queue, and so does
      // a read-out. The spare codes come next. Then the queue is filled to
      // depth with extreme keys and texts and with duplicate keys. The queue
      // refuses one append when full and is read out whole. Then come a
      // removal of a duplicate key, a removal of an absent key, and a
      // removal of the tail.
      pending_cmds.push_back(make_cmd(CMD_READ_OUT, 16'h0000, TEXT_RANDOM));
      pending_cmds.push_back(make_cmd(CMD_REM_HEAD, 16'h0000, TEXT_RANDOM));
      pending_cmds.push_back(make_cmd(CMD_REM_TAIL, 16'h0000, TEXT_RANDOM));
      pending_cmds.push_back(make_cmd(CMD_REM_KEY, 16'h0000, TEXT_RANDOM));
      pending_cmds.push_back(make_cmd(CMD_SPARE_LO, 16'hFFFF, TEXT_ONES));
      pending_cmds.push_back(make_cmd(CMD_SPARE_HI, 16'h0000, TEXT_ZERO));
      pending_cmds.push_back(make_cmd(CMD_APPEND, 16'h0000, TEXT_ZERO));
      pending_cmds.push_back(make_cmd(CMD_APPEND, 16'hFFFF, TEXT_ONES));
      for (int i = 2; i < DEPTH; i++) begin
         pending_cmds.push_back(make_cmd(CMD_APPEND, 16'(i % 4), TEXT_RANDOM));
      end
      pending_cmds.push_back(make_cmd(CMD_APPEND, 16'h0005, TEXT_RANDOM));
      pending_cmds.push_back(make_cmd(CMD_READ_OUT, 16'h0000, TEXT_RANDOM));
      pending_cmds.push_back(make_cmd(CMD_REM_KEY, 16'h0002, TEXT_RANDOM));
      pending_cmds.push_back(make_cmd(CMD_REM_KEY, 16'h1234, TEXT_RANDOM));
      pending_cmds.push_back(make_cmd(CMD_REM_TAIL, 16'h0000, TEXT_RANDOM));

      // Random part. Blocks of 30 commands alternate between a bias toward
      // appends and a bias toward removals, so that the queue swings between
      // full and empty again and again. Each command carries random content.
      append_pct = 55;
      for (int n = 0; n < RANDOM_CMDS; n++) begin
         if (n % 30 == 0) begin
            append_pct = (append_pct == 55) ? 20 : 55;
         end
         pick = $urandom_range(99);
         if (pick < append_pct) begin
            code = CMD_APPEND;
         end else if (pick < append_pct + 8) begin
            code = CMD_REM_HEAD;
         end else if (pick < append_pct + 16) begin
            code = CMD_REM_TAIL;
         end else if (pick < append_pct + 26) begin
            code = CMD_READ_OUT;
         end else if (pick < append_pct + 28) begin
            code = 3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
         end else begin
            code = CMD_REM_KEY;
         end
         key = pick_key();
         pending_cmds.push_back(make_cmd(code, key, TEXT_RANDOM));
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Wait until the driver has handed over every item and the last one
      // has been taken. Then wait until the block has given every owed
      // answer. The final pause catches any stray result that comes late.
      while (pending_cmds.size() != 0 || start) begin
         @(posedge clock);
      end
      while (owed_answers.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("queue_with_keyed_removal_top: match");
      end else begin
         $display("queue_with_keyed_removal_top: mismatch");
      end
      $finish;
   end

endmodule
